FILE: rtl/max_pool_with_argmax_defines.svh
// Assertion macros shared by the max pooling block.
// Depends on signals clk and arst_n being visible where a macro is used.
`ifndef MAX_POOL_WITH_ARGMAX_DEFINES_SVH
`define MAX_POOL_WITH_ARGMAX_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MPA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define MPA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mpa_pkg.sv
// Types and constants for the max pooling block with arg-max.
// No dependencies; imported by mpa_engine and max_pool_with_argmax.
`default_nettype none

package mpa_pkg;

	localparam int MAX_CHANNELS = 8;
	localparam int MAX_HEIGHT   = 32;
	localparam int MAX_WIDTH    = 32;
	localparam int SAMPLE_BITS  = 16;

	localparam int CH_BITS    = $clog2(MAX_CHANNELS);
	localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
	localparam int COL_BITS   = $clog2(MAX_WIDTH);
	localparam int ADDR_BITS  = CH_BITS + ROW_BITS + COL_BITS;
	localparam int STORE_DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN =
		{1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// configuration register indexes
	localparam logic [2:0] REG_CHANNEL_COUNT = 3'd0;
	localparam logic [2:0] REG_PLANE_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_PLANE_WIDTH   = 3'd2;
	localparam logic [2:0] REG_WINDOW_SIZE   = 3'd3;
	localparam logic [2:0] REG_WINDOW_STEP   = 3'd4;
	localparam logic [2:0] REG_BORDER_PAD    = 3'd5;

	// item actions
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic                          action;
		logic [2:0]                    channel;
		logic [5:0]                    row;
		logic [5:0]                    column;
		logic signed [SAMPLE_BITS-1:0] sample_value;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] max_value;
		logic [12:0]                   winner_index;
		logic                          winner_found;
	} out_item_t;

	// configuration after saturation to the legal ranges
	typedef struct packed {
		logic [3:0] chans;
		logic [5:0] height;
		logic [5:0] width;
		logic [3:0] ksize;
		logic [3:0] step;
		logic [2:0] pad;
	} cfg_t;

	// requests from the port logic to the engine
	typedef struct packed {
		logic query;
		logic write;
	} eng_req_t;

	// engine status back to the port logic
	typedef struct packed {
		logic busy;
		logic res_valid;
	} eng_stat_t;

endpackage

`default_nettype wire

FILE: rtl/mpa_engine.sv
// Sample store and window scan sequencer with a shared compare unit.
// Depends on mpa_pkg and max_pool_with_argmax_defines.svh.
`default_nettype none

`include "max_pool_with_argmax_defines.svh"

module mpa_engine
	import mpa_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire eng_req_t  req,
	input  wire in_item_t  item,
	input  wire logic      res_ready,
	output eng_stat_t      stat,
	output out_item_t      res
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_IDX1  = 3'd4;
	localparam logic [2:0] ST_IDX2  = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0] state_q;

	logic signed [SAMPLE_BITS-1:0] mem [STORE_DEPTH];

	// query context
	logic [CH_BITS-1:0] ch_q;
	logic [5:0]         qrow_q;
	logic [5:0]         qcol_q;
	logic               ch_ok_q;
	logic signed [10:0] r0_q;
	logic signed [10:0] c0_q;
	logic [2:0]         kr_q;
	logic [2:0]         kc_q;

	// compare stage
	logic                          vld_s1;
	logic [ROW_BITS-1:0]           ir_s1;
	logic [COL_BITS-1:0]           ic_s1;
	logic signed [SAMPLE_BITS-1:0] rd_s1;

	// running best
	logic signed [SAMPLE_BITS-1:0] best_q;
	logic [ROW_BITS-1:0]           best_r_q;
	logic [COL_BITS-1:0]           best_c_q;
	logic                          found_q;
	logic [8:0]                    rsum_q;
	logic [12:0]                   idx_q;

	logic [9:0]          rprod;
	logic [9:0]          cprod;
	logic signed [10:0]  ir;
	logic signed [10:0]  ic;
	logic                inb;
	logic                last_c;
	logic                last_r;
	logic [ADDR_BITS-1:0] rd_addr;
	logic [ADDR_BITS-1:0] wr_addr;
	logic [8:0]          ch_h;
	logic [12:0]         idx_next;

	assign rprod = 10'(qrow_q * cfg.step);
	assign cprod = 10'(qcol_q * cfg.step);

	assign ir = r0_q + $signed({8'd0, kr_q});
	assign ic = c0_q + $signed({8'd0, kc_q});
	assign inb = ch_ok_q && !ir[10] && (ir[9:0] < {4'd0, cfg.height})
		&& !ic[10] && (ic[9:0] < {4'd0, cfg.width});

	assign last_c = ({1'b0, kc_q} == (cfg.ksize - 4'd1));
	assign last_r = ({1'b0, kr_q} == (cfg.ksize - 4'd1));

	assign rd_addr = {ch_q, ir[ROW_BITS-1:0], ic[COL_BITS-1:0]};
	assign wr_addr = {item.channel, item.row[ROW_BITS-1:0], item.column[COL_BITS-1:0]};

	assign ch_h = {6'd0, ch_q} * {3'd0, cfg.height};
	assign idx_next = 13'({4'd0, rsum_q} * {7'd0, cfg.width}) + {8'd0, best_c_q};

	// sample store: one write port (idle only), one registered read port
	always_ff @(posedge clk) begin
		if (req.write) begin
			mem[wr_addr] <= item.sample_value;
		end
		rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN) && inb;
			if (vld_s1 && (!found_q || (rd_s1 > best_q))) begin
				found_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.query) begin
						state_q <= ST_SETUP;
						found_q <= 1'b0;
					end
				end
				ST_SETUP: state_q <= ST_SCAN;
				ST_SCAN: begin
					if (last_c && last_r) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_IDX1;
				ST_IDX1:  state_q <= ST_IDX2;
				ST_IDX2:  state_q <= ST_DONE;
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		ir_s1 <= ir[ROW_BITS-1:0];
		ic_s1 <= ic[COL_BITS-1:0];
		if (vld_s1 && (!found_q || (rd_s1 > best_q))) begin
			best_q   <= rd_s1;
			best_r_q <= ir_s1;
			best_c_q <= ic_s1;
		end
		case (state_q)
			ST_IDLE: begin
				if (req.query) begin
					ch_q    <= item.channel;
					qrow_q  <= item.row;
					qcol_q  <= item.column;
					ch_ok_q <= ({1'b0, item.channel} < cfg.chans);
					best_q  <= SAMPLE_MIN;
				end
			end
			ST_SETUP: begin
				r0_q <= $signed({1'b0, rprod}) - $signed({8'd0, cfg.pad});
				c0_q <= $signed({1'b0, cprod}) - $signed({8'd0, cfg.pad});
				kr_q <= 3'd0;
				kc_q <= 3'd0;
			end
			ST_SCAN: begin
				if (last_c) begin
					kc_q <= 3'd0;
					kr_q <= kr_q + 3'd1;
				end else begin
					kc_q <= kc_q + 3'd1;
				end
			end
			ST_IDX1: rsum_q <= ch_h + {4'd0, best_r_q};
			ST_IDX2: idx_q  <= found_q ? idx_next : 13'd0;
			default: ;
		endcase
	end

	assign stat.busy      = (state_q != ST_IDLE);
	assign stat.res_valid = (state_q == ST_DONE);
	assign res.max_value    = best_q;
	assign res.winner_index = idx_q;
	assign res.winner_found = found_q;

	`MPA_ASSERT_NOW(a_start_idle, req.query || req.write, state_q == ST_IDLE,
		"request while engine busy")
	`MPA_ASSERT_NOW(a_empty_min, (state_q == ST_DONE) && !found_q,
		(best_q == SAMPLE_MIN) && (idx_q == 13'd0), "empty window result not cleared")
	`MPA_ASSERT_NOW(a_inplane, vld_s1,
		({1'b0, ir_s1} < cfg.height) && ({1'b0, ic_s1} < cfg.width),
		"compared sample outside the plane")
	`MPA_ASSERT_NEXT(a_drain_idx, state_q == ST_DRAIN, state_q == ST_IDX1,
		"drain not followed by index step")
	`MPA_ASSERT_NEXT(a_done_hold, (state_q == ST_DONE) && !res_ready,
		(state_q == ST_DONE) && $stable(res), "result changed while held")

endmodule

`default_nettype wire

FILE: rtl/max_pool_with_argmax.sv
// 2-D max pooling with arg-max over one stored multi-channel image.
// Channels: in (in_valid/in_stall/in_item) and out (out_valid/out_stall/out_item),
// an item moves on a clock edge where valid is high and stall is low.
// Configuration: cfg_wr_en/cfg_index/cfg_data, written by the user only while the
// block is idle; the block itself does not enforce this. A write item (action 0)
// stores one sample and returns nothing; out-of-range positions are dropped.
// A query item (action 1) scans window_size x window_size positions, one store
// read per cycle through a single compare unit. The result passes through the setup,
// scan, drain and index steps of the engine before the output register takes it;
// the single read port of the sample store sets the scan length.
// in_stall stays high from a query transaction until its result is taken into the
// output register; writes are taken one per cycle while no query is in progress.
// A finished result sits in the output register; writes are still taken while it
// waits, and a later query finishes its scan and holds until out_stall drops.
// Reset clears the registers to their defaults and empties the output register;
// the sample store keeps no reset value and must be written before it is queried.
// Depends on mpa_pkg and mpa_engine.
`default_nettype none

module max_pool_with_argmax
	import mpa_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_item,
	input  wire logic      cfg_wr_en,
	input  wire logic [2:0] cfg_index,
	input  wire logic [5:0] cfg_data
);

	logic [3:0] chans_q;
	logic [5:0] height_q;
	logic [5:0] width_q;
	logic [3:0] ksize_q;
	logic [3:0] step_q;
	logic [2:0] pad_q;

	cfg_t      cfg;
	eng_req_t  req;
	eng_stat_t stat;
	out_item_t res;
	logic      accept;
	logic      res_ready;
	logic      wr_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chans_q  <= 4'd1;
			height_q <= 6'd32;
			width_q  <= 6'd32;
			ksize_q  <= 4'd2;
			step_q   <= 4'd2;
			pad_q    <= 3'd0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_CHANNEL_COUNT: chans_q  <= cfg_data[3:0];
				REG_PLANE_HEIGHT:  height_q <= cfg_data;
				REG_PLANE_WIDTH:   width_q  <= cfg_data;
				REG_WINDOW_SIZE:   ksize_q  <= cfg_data[3:0];
				REG_WINDOW_STEP:   step_q   <= cfg_data[3:0];
				REG_BORDER_PAD:    pad_q    <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// registers as used: saturated to their legal ranges
	always_comb begin
		cfg.chans  = (chans_q == 4'd0) ? 4'd1 : ((chans_q > 4'd8) ? 4'd8 : chans_q);
		cfg.height = (height_q == 6'd0) ? 6'd1 : ((height_q > 6'd32) ? 6'd32 : height_q);
		cfg.width  = (width_q == 6'd0) ? 6'd1 : ((width_q > 6'd32) ? 6'd32 : width_q);
		cfg.ksize  = (ksize_q == 4'd0) ? 4'd1 : ((ksize_q > 4'd8) ? 4'd8 : ksize_q);
		cfg.step   = (step_q == 4'd0) ? 4'd1 : ((step_q > 4'd8) ? 4'd8 : step_q);
		cfg.pad    = pad_q;
	end

	assign in_stall = stat.busy;
	assign accept   = in_valid && !in_stall;

	assign wr_ok = ({1'b0, in_item.channel} < cfg.chans) && (in_item.row < cfg.height)
		&& (in_item.column < cfg.width);
	assign req.write = accept && (in_item.action == ACT_WRITE) && wr_ok;
	assign req.query = accept && (in_item.action == ACT_QUERY);

	assign res_ready = !out_valid || !out_stall;

	mpa_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req       (req),
		.item      (in_item),
		.res_ready (res_ready),
		.stat      (stat),
		.res       (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (stat.res_valid && res_ready) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.res_valid && res_ready) begin
			out_item <= res;
		end
	end

endmodule

`default_nettype wire
